FILE: sv/dmps_pkg.sv
// package for the diamond max path sum block
// widths, payload types, the per-cell control struct and the saturating add
// no dependencies
package dmps_pkg;

    localparam int MAX_SIDE = 256;
    localparam int ADDR_W   = $clog2(MAX_SIDE);
    localparam int SIDE_W   = 9;
    localparam int CELL_W   = 16;
    localparam int SUM_W    = 25;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [SIDE_W-1:0] t_side;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [SUM_W-1:0]  t_sum;

    typedef struct packed {
        t_addr col;
        logic  first_row;
        logic  col_zero;
        logic  col_end;
        logic  lower;
        logic  last;
    } t_cell_ctl;

    function automatic t_sum sat_add(input t_sum a, input t_cell b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

FILE: sv/dmps_cell_if.sv
// cell value channel
// depends on dmps_pkg
interface dmps_cell_if;
    logic             valid;
    logic             ready;
    dmps_pkg::t_cell  cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

FILE: sv/dmps_sum_if.sv
// best path sum result channel
// depends on dmps_pkg
interface dmps_sum_if;
    logic            valid;
    logic            ready;
    dmps_pkg::t_sum  best_sum;

    modport source (output valid, output best_sum, input ready);
    modport sink   (input valid, input best_sum, output ready);
endinterface

FILE: sv/dmps_cfg_if.sv
// side length configuration write channel
// depends on dmps_pkg
interface dmps_cfg_if;
    logic             valid;
    logic             ready;
    dmps_pkg::t_side  side_length;

    modport source (output valid, output side_length, input ready);
    modport sink   (input valid, input side_length, output ready);
endinterface

FILE: sv/diamond_max_path_sum.sv
// diamond max path sum, top level
// depends on dmps_pkg, dmps_cell_if, dmps_sum_if, dmps_cfg_if, dmps_seq, dmps_row_store
//
// usage:
//   i_cfg sets side_length (rows in the growing half) and rearms the block;
//   write it only while the block is idle, it is always ready
//   i_cell takes cell values in row order, one transfer per cycle: rows of
//   1..n cells then n-1..1 cells
//   o_sum gives one best_sum transfer after the last cell of each diamond
// timing:
//   a cell is registered together with its row store reads, and the next
//   edge writes the updated sum back and, for the last cell, loads the result
//   register, so best_sum shows one cycle after the last cell transfer
//   throughput is one cell per cycle, set by the single row store write port;
//   a write to the address being read in the same cycle is forwarded
// reset: side_length 1, first row, first column, no result pending
// stall: while a result waits in the output register a further last cell
//   holds in the work stage and i_cell drops ready; other cells keep flowing
module diamond_max_path_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmps_cell_if.sink   i_cell,
    dmps_cfg_if.sink    i_cfg,
    dmps_sum_if.source  o_sum
);
    import dmps_pkg::*;

    t_cell_ctl seq_ctl;
    logic      in_fire;
    logic      s1_fire;

    logic      r_s1_valid;
    t_cell_ctl r_s1_ctl;
    t_cell     r_s1_cell;
    logic      r_hit0;
    logic      r_hit1;
    t_sum      r_fwd;
    t_sum      r_held;
    logic      r_out_valid;
    t_sum      r_best;

    t_sum      mem_q0;
    t_sum      mem_q1;
    t_sum      up_here;
    t_sum      up_right;
    t_sum      base;
    t_sum      s1_sum;
    logic      n_out_valid;

    assign i_cfg.ready = 1'b1;

    assign s1_fire = r_s1_valid && (!r_s1_ctl.last || !r_out_valid || o_sum.ready);
    assign i_cell.ready = !r_s1_valid || s1_fire;
    assign in_fire = i_cell.valid && i_cell.ready;

    dmps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_side (i_cfg.side_length),
        .i_adv      (in_fire),
        .o_ctl      (seq_ctl)
    );

    dmps_row_store u_store (
        .i_clk    (i_clk),
        .i_we     (s1_fire),
        .i_waddr  (r_s1_ctl.col),
        .i_wdata  (s1_sum),
        .i_re     (in_fire),
        .i_raddr0 (seq_ctl.col),
        .i_raddr1 (seq_ctl.col + ADDR_W'(1)),
        .o_rdata0 (mem_q0),
        .o_rdata1 (mem_q1)
    );

    always_comb begin
        up_here  = r_hit0 ? r_fwd : mem_q0;
        up_right = r_hit1 ? r_fwd : mem_q1;
        if (r_s1_ctl.lower) begin
            base = (up_here > up_right) ? up_here : up_right;
        end else if (r_s1_ctl.first_row) begin
            base = '0;
        end else if (r_s1_ctl.col_zero) begin
            base = up_here;
        end else if (r_s1_ctl.col_end) begin
            base = r_held;
        end else begin
            base = (r_held > up_here) ? r_held : up_here;
        end
        s1_sum = sat_add(base, r_s1_cell);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_fire && r_s1_ctl.last) begin
            n_out_valid = 1'b1;
        end else if (o_sum.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_held <= up_here;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ctl  <= seq_ctl;
            r_s1_cell <= i_cell.cell_value;
            r_hit0    <= s1_fire && (r_s1_ctl.col == seq_ctl.col);
            r_hit1    <= s1_fire && (r_s1_ctl.col == seq_ctl.col + ADDR_W'(1));
            r_fwd     <= s1_sum;
        end
        if (s1_fire && r_s1_ctl.last) begin
            r_best <= s1_sum;
        end
    end

    assign o_sum.valid    = r_out_valid;
    assign o_sum.best_sum = r_best;

    // a waiting result is never overwritten
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_sum.ready |=> r_out_valid && $stable(r_best))
        else $error("pending result lost");

    // the last cell of a diamond sits in the first column
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_ctl.last |-> r_s1_ctl.col == '0)
        else $error("last cell not in first column");

    // a result comes only from the lower half or a single-row diamond
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_ctl.last |-> r_s1_ctl.lower || r_s1_ctl.first_row)
        else $error("result from inner row");

endmodule

FILE: sv/dmps_row_store.sv
// row store of best path sums, one write port and two registered read ports
// depends on dmps_pkg
module dmps_row_store (
    input  logic           i_clk,
    input  logic           i_we,
    input  dmps_pkg::t_addr i_waddr,
    input  dmps_pkg::t_sum  i_wdata,
    input  logic           i_re,
    input  dmps_pkg::t_addr i_raddr0,
    input  dmps_pkg::t_addr i_raddr1,
    output dmps_pkg::t_sum  o_rdata0,
    output dmps_pkg::t_sum  o_rdata1
);
    import dmps_pkg::*;

    t_sum r_mem [MAX_SIDE];
    t_sum r_rdata0;
    t_sum r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

FILE: sv/dmps_seq.sv
// row and column sequencer, holds the side length register
// depends on dmps_pkg
module dmps_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  dmps_pkg::t_side   i_cfg_side,
    input  logic              i_adv,
    output dmps_pkg::t_cell_ctl o_ctl
);
    import dmps_pkg::*;

    t_side r_side;
    t_side r_row;
    t_addr r_col;
    logic  r_lower;

    t_side n_row;
    t_addr n_col;
    logic  n_lower;

    t_side side_eff;
    t_side row_g;
    t_side row_l;
    t_side row_len;
    logic  row_done;
    logic  last;

    always_comb begin
        if (r_side == '0) begin
            side_eff = SIDE_W'(1);
        end else if (r_side > SIDE_W'(MAX_SIDE)) begin
            side_eff = SIDE_W'(MAX_SIDE);
        end else begin
            side_eff = r_side;
        end

        row_g = (r_row == '0 || r_row > side_eff) ? SIDE_W'(1) : r_row;
        row_l = (r_row == '0 || r_row >= side_eff) ? SIDE_W'(1) : r_row;
        row_len  = r_lower ? side_eff - row_l : row_g;
        row_done = (SIDE_W'(r_col) + SIDE_W'(1)) >= row_len;

        last    = 1'b0;
        n_row   = r_row;
        n_col   = r_col + ADDR_W'(1);
        n_lower = r_lower;
        if (row_done) begin
            n_col = '0;
            if (!r_lower) begin
                if (r_row < side_eff) begin
                    n_row = r_row + SIDE_W'(1);
                end else if (side_eff == SIDE_W'(1)) begin
                    last  = 1'b1;
                    n_row = SIDE_W'(1);
                end else begin
                    n_lower = 1'b1;
                    n_row   = SIDE_W'(1);
                end
            end else if (row_len > SIDE_W'(1)) begin
                n_row = r_row + SIDE_W'(1);
            end else begin
                last    = 1'b1;
                n_row   = SIDE_W'(1);
                n_lower = 1'b0;
            end
        end
    end

    always_comb begin
        o_ctl.col       = r_col;
        o_ctl.first_row = !r_lower && (row_g == SIDE_W'(1));
        o_ctl.col_zero  = (r_col == '0);
        o_ctl.col_end   = (SIDE_W'(r_col) == row_g - SIDE_W'(1));
        o_ctl.lower     = r_lower;
        o_ctl.last      = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SIDE_W'(1);
            r_row   <= SIDE_W'(1);
            r_col   <= '0;
            r_lower <= 1'b0;
        end else if (i_cfg_we) begin
            r_side  <= i_cfg_side;
            r_row   <= SIDE_W'(1);
            r_col   <= '0;
            r_lower <= 1'b0;
        end else if (i_adv) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_lower <= n_lower;
        end
    end

    // column stays inside the diamond width
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SIDE_W'(r_col) < side_eff)
        else $error("column beyond side length");

    // lower half never holds a row past its last one
    a_lower_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lower |-> r_row < side_eff)
        else $error("lower half row out of range");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// testbench for diamond_max_path_sum: feeds diamonds of cell values under several side lengths,
// predicts every best path sum from its own copy of the row state and checks each result transfer
// depends on dmps_pkg, dmps_cell_if, dmps_cfg_if, dmps_sum_if and diamond_max_path_sum
module tb_top;
    import dmps_pkg::*;

    localparam int IDLE_PCT   = 18;
    localparam int SINK_HOLD  = 200;
    localparam int DRAIN      = 6;
    localparam int RAND_CELLS = 380;
    localparam int QUIET_RUN  = 150;
    localparam int WIDE_CELLS = 60;

    logic i_clk;
    logic i_rst_n;

    dmps_cell_if cell_bus();
    dmps_cfg_if  cfg_bus();
    dmps_sum_if  sum_bus();

    diamond_max_path_sum u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_bus),
        .i_cfg   (cfg_bus),
        .o_sum   (sum_bus)
    );

    t_sum        pending_sums[$];
    int unsigned err_cnt;
    int unsigned cur_n;
    bit          gaps_on;
    bit          hold_req;

    // predicted diamond state
    t_sum  path_best [MAX_SIDE];
    t_side side_reg;
    t_side row_no;
    t_addr col_no;
    t_sum  left_keep;
    bit    lower_half;

    function automatic t_sum clip_add(input t_sum a, input t_cell b);
        logic [SUM_W:0] wide;
        wide = {1'b0, a} + (SUM_W + 1)'(b);
        return (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
    endfunction

    function automatic int unsigned side_eff(input t_side s);
        if (s == 0) return 1;
        if (s > MAX_SIDE) return MAX_SIDE;
        return 32'(s);
    endfunction

    function automatic void restart_diamond();
        row_no     = 1;
        col_no     = 0;
        left_keep  = 0;
        lower_half = 1'b0;
    endfunction

    function automatic void predict_best_sum(input t_cell v);
        int unsigned n;
        int unsigned r;
        int unsigned len;
        t_sum        old;
        t_sum        val;
        n = side_eff(side_reg);
        if (!lower_half) begin
            r = 32'(row_no);
            if (r < 1 || r > n) r = 1;
            len = r;
            old = path_best[col_no];
            if (r == 1) begin
                val = t_sum'(v);
            end else if (col_no == 0) begin
                val = clip_add(old, v);
            end else if (col_no == r - 1) begin
                val = clip_add(left_keep, v);
            end else begin
                val = clip_add((left_keep > old) ? left_keep : old, v);
            end
            path_best[col_no] = val;
            left_keep = old;
        end else begin
            r = 32'(row_no);
            if (r < 1 || r >= n) r = 1;
            len = n - r;
            old = path_best[col_no + t_addr'(1)];
            val = path_best[col_no];
            path_best[col_no] = clip_add((val > old) ? val : old, v);
        end
        if (col_no + 1 < len) begin
            col_no = col_no + t_addr'(1);
            return;
        end
        col_no    = 0;
        left_keep = 0;
        if (!lower_half) begin
            if (row_no < n) begin
                row_no = row_no + t_side'(1);
                return;
            end
            if (n == 1) begin
                pending_sums = {pending_sums, path_best[0]};
                restart_diamond();
                return;
            end
            lower_half = 1'b1;
            row_no     = 1;
            return;
        end
        if (len > 1) begin
            row_no = row_no + t_side'(1);
            return;
        end
        pending_sums = {pending_sums, path_best[0]};
        restart_diamond();
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result receiver with random idling and a long hold-off on request
    initial begin
        sum_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                sum_bus.ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
            end else begin
                sum_bus.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // predictor and checker, fed from the transfers seen at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SIDE; i++) path_best[i] = '0;
            side_reg = 1;
            restart_diamond();
            pending_sums.delete();
        end else begin
            if (sum_bus.valid && sum_bus.ready) begin
                if (pending_sums.size() == 0) begin
                    $display("%0t: unexpected best_sum, expected none, actual %0d",
                             $time, sum_bus.best_sum);
                    err_cnt++;
                end else if (sum_bus.best_sum !== pending_sums[0]) begin
                    $display("%0t: best_sum mismatch, expected %0d, actual %0d",
                             $time, pending_sums[0], sum_bus.best_sum);
                    err_cnt++;
                    void'(pending_sums.pop_front());
                end else begin
                    void'(pending_sums.pop_front());
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                side_reg = cfg_bus.side_length;
                restart_diamond();
            end
            if (cell_bus.valid && cell_bus.ready) predict_best_sum(cell_bus.cell_value);
        end
    end

    function automatic t_cell rand_cell();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_cell'($urandom_range(0, 15));
            default: return t_cell'($urandom);
        endcase
    endfunction

    task automatic send_cell(input t_cell v);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            cell_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_bus.valid      <= 1'b1;
        cell_bus.cell_value <= v;
        @(posedge i_clk);
        while (!cell_bus.ready) @(posedge i_clk);
    endtask

    task automatic send_random_cells(input int unsigned cnt);
        for (int unsigned i = 0; i < cnt; i++) send_cell(rand_cell());
    endtask

    // stop offering cells and wait until every predicted sum has been taken
    task automatic settle();
        cell_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_side(input t_side s);
        settle();
        cfg_bus.valid       <= 1'b1;
        cfg_bus.side_length <= s;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        cur_n = side_eff(s);
    endtask

    // side 1 straight from reset, then side 0 which acts as 1
    task automatic test_single_row();
        send_cell(16'h0000);
        send_cell(16'hFFFF);
        send_cell(16'h0001);
        send_cell(16'h8000);
        write_side(0);
        send_cell(16'hAAAA);
        send_cell(16'h5555);
    endtask

    task automatic test_small_diamonds();
        write_side(2);
        repeat (4) send_cell(16'hFFFF);
        write_side(3);
        send_cell(10);
        send_cell(3);
        send_cell(3);
        send_cell(1);
        send_cell(9);
        send_cell(1);
        send_cell(4);
        send_cell(4);
        send_cell(2);
    endtask

    // a write in the middle of a diamond drops the cells seen so far
    task automatic test_rearm();
        write_side(3);
        send_random_cells(5);
        write_side(2);
        send_cell(16'h0007);
        send_cell(16'hFFFF);
        send_cell(16'h0000);
        send_cell(16'h1234);
    endtask

    // largest side, then an oversized side that acts as the largest, first rows only
    task automatic test_wide_sides();
        write_side(t_side'(MAX_SIDE));
        send_random_cells(WIDE_CELLS);
        write_side('1);
        repeat (WIDE_CELLS) send_cell('1);
        write_side(1);
    endtask

    task automatic test_backpressure();
        write_side(1);
        gaps_on  <= 1'b0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        send_random_cells(40);
        settle();
        write_side(3);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        send_random_cells(4 * 9);
        gaps_on <= 1'b1;
        settle();
    endtask

    task automatic test_random();
        int unsigned sent;
        int unsigned cnt;
        sent = 0;
        while (sent < RAND_CELLS) begin
            gaps_on <= (sent >= QUIET_RUN);
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 99) < 8) write_side(t_side'($urandom_range(9, 16)));
                else write_side(t_side'($urandom_range(0, 8)));
            end
            if (cur_n > 1 && $urandom_range(0, 99) < 10) begin
                // broken diamond, rearmed by the next side write
                cnt = $urandom_range(1, cur_n * cur_n - 1);
                send_random_cells(cnt);
                write_side(t_side'($urandom_range(0, 8)));
            end else begin
                cnt = cur_n * cur_n;
                send_random_cells(cnt);
            end
            sent += cnt;
        end
    endtask

    initial begin
        int unsigned wait_cnt;
        err_cnt              = 0;
        cur_n                = 1;
        i_rst_n             <= 1'b0;
        gaps_on             <= 1'b1;
        hold_req            <= 1'b0;
        cell_bus.valid      <= 1'b0;
        cell_bus.cell_value <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.side_length <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_row();
        test_small_diamonds();
        test_rearm();
        test_backpressure();
        test_wide_sides();
        test_random();

        cell_bus.valid <= 1'b0;
        @(posedge i_clk);
        wait_cnt = 0;
        while (pending_sums.size() != 0 && wait_cnt < 2000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN) @(posedge i_clk);
        if (pending_sums.size() != 0) begin
            $display("%0t: %0d best_sum results never arrived, expected %0d first, actual none",
                     $time, pending_sums.size(), pending_sums[0]);
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
